[hw/rtl/rsrg_pkg.sv]
package rsrg_pkg;

  localparam int VALUE_W = 32;
  localparam int RUN_W   = 16;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0] WORK_SIZE_RESET = 7'd64;
  localparam logic [RUN_W-1:0] RUN_MAX         = 16'hFFFF;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic take_in;     // capture the input request
    logic fill_wr;     // append record while the area is filling
    logic scan_init;   // clear scan pointer and best-so-far
    logic scan_rd;     // read the slot at the scan pointer, advance it
    logic emit;        // pick the winner, load the output register
    logic write_back;  // refill the chosen slot
    logic drain_end;   // area empty after drain, reset run state
  } rsrg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_drain;
    logic area_full;
    logic occ_zero;
    logic scan_last;
    logic out_free;
  } rsrg_sts_t;

  // signed order onto unsigned order
  function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v);
    order_key = {~v[VALUE_W-1], v[VALUE_W-2:0]};
  endfunction

endpackage

[hw/rtl/rsrg_if.sv]
interface rsrg_in_if import rsrg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [VALUE_W-1:0] record_value;

  modport source (output valid, cmd, record_value, input ready);
  modport sink   (input valid, cmd, record_value, output ready);
endinterface

interface rsrg_out_if import rsrg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic        [RUN_W-1:0]   run_index;
  logic                      first_of_run;
  logic                      final_record;

  modport source (output valid, out_value, run_index, first_of_run, final_record,
                  input ready);
  modport sink   (input valid, out_value, run_index, first_of_run, final_record,
                  output ready);
endinterface

[hw/rtl/rsrg_ram.sv]
module rsrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/rsrg_ctrl.sv]
module rsrg_ctrl import rsrg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rsrg_sts_t sts,
  output rsrg_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_drain) begin
          if (sts.occ_zero) begin
            cmd.drain_end = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end else if (sts.area_full) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.fill_wr = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        // last slot compares this cycle
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_back = 1'b1;
        state_next     = sts.is_drain ? S_DECIDE : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/rsrg_dp.sv]
module rsrg_dp import rsrg_pkg::*; #(
  parameter int WORK_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [RUN_W-1:0]          out_run,
  output logic                      out_first,
  output logic                      out_final,
  input  rsrg_cmd_t                 cmd,
  output rsrg_sts_t                 sts
);

  localparam int AW    = $clog2(WORK_DEPTH);
  localparam int OCC_W = $clog2(WORK_DEPTH + 1);
  localparam logic [OCC_W-1:0] OCC_ONE   = OCC_W'(1);
  localparam logic [CFG_W-1:0] DEPTH_CFG = CFG_W'(WORK_DEPTH);

  logic [CFG_W-1:0]   work_size;
  logic [CFG_W-1:0]   size_use;
  logic [OCC_W-1:0]   occ;
  logic               run_has;
  logic [RUN_W-1:0]   current_run;
  logic [VALUE_W-1:0] last_emitted;

  logic               cmd_q;
  logic [VALUE_W-1:0] val_q;

  logic [AW-1:0]      rd_idx;
  logic               cmp_vld;
  logic [AW-1:0]      cmp_idx;
  logic [VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0] rd_key;

  logic               q_found;
  logic [VALUE_W-1:0] q_val;
  logic [AW-1:0]      q_idx;
  logic               a_found;
  logic [VALUE_W-1:0] a_val;
  logic [AW-1:0]      a_idx;
  logic [VALUE_W-1:0] last_val;
  logic [AW-1:0]      sel_idx;

  logic               qual;
  logic               use_q;
  logic [RUN_W-1:0]   run_inc;
  logic [RUN_W-1:0]   run_new;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;

  // slots in use, clamped to 1..WORK_DEPTH
  always_comb begin
    if (work_size == '0) begin
      size_use = CFG_W'(1);
    end else if (work_size > DEPTH_CFG) begin
      size_use = DEPTH_CFG;
    end else begin
      size_use = work_size;
    end
  end

  assign sts.is_drain  = (cmd_q == CMD_DRAIN);
  assign sts.area_full = (CFG_W'(occ) >= size_use);
  assign sts.occ_zero  = (occ == '0);
  assign sts.scan_last = (OCC_W'(rd_idx) == occ - OCC_ONE);
  assign sts.out_free  = !out_valid || out_ready;

  assign ram_we    = cmd.fill_wr || cmd.write_back;
  assign ram_waddr = cmd.fill_wr ? occ[AW-1:0] : sel_idx;
  assign ram_wdata = (cmd.write_back && cmd_q == CMD_DRAIN) ? last_val : val_q;

  rsrg_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (WORK_DEPTH)
  ) u_work (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  assign rd_key = order_key(rd_data);
  assign qual   = !run_has || (rd_key >= order_key(last_emitted));

  assign use_q   = run_has && q_found;
  assign run_inc = (current_run != RUN_MAX) ? current_run + RUN_W'(1) : current_run;
  assign run_new = (run_has && !q_found) ? run_inc : current_run;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      work_size    <= WORK_SIZE_RESET;
      occ          <= '0;
      run_has      <= 1'b0;
      current_run  <= '0;
      last_emitted <= '0;
      cmp_vld      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        work_size <= cfg_wdata;
      end
      cmp_vld <= cmd.scan_rd;
      if (cmd.fill_wr) begin
        occ <= occ + OCC_ONE;
      end else if (cmd.write_back && cmd_q == CMD_DRAIN) begin
        occ <= occ - OCC_ONE;
      end
      if (cmd.emit) begin
        run_has      <= 1'b1;
        current_run  <= run_new;
        last_emitted <= use_q ? q_val : a_val;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.drain_end) begin
        occ          <= '0;
        run_has      <= 1'b0;
        current_run  <= '0;
        last_emitted <= '0;
      end
    end
  end

  // payload and scan state
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      cmd_q <= in_cmd;
      val_q <= in_value;
    end
    if (cmd.scan_init) begin
      rd_idx  <= '0;
      q_found <= 1'b0;
      a_found <= 1'b0;
    end else if (cmd.scan_rd) begin
      rd_idx <= rd_idx + AW'(1);
    end
    cmp_idx <= rd_idx;
    if (cmp_vld) begin
      // strict less keeps the lowest slot on ties
      if (qual && (!q_found || rd_key < order_key(q_val))) begin
        q_found <= 1'b1;
        q_val   <= rd_data;
        q_idx   <= cmp_idx;
      end
      if (!a_found || rd_key < order_key(a_val)) begin
        a_found <= 1'b1;
        a_val   <= rd_data;
        a_idx   <= cmp_idx;
      end
      if (OCC_W'(cmp_idx) == occ - OCC_ONE) begin
        last_val <= rd_data;
      end
    end
    if (cmd.emit) begin
      sel_idx   <= use_q ? q_idx : a_idx;
      out_value <= use_q ? q_val : a_val;
      out_run   <= run_new;
      out_first <= !use_q;
      out_final <= (cmd_q == CMD_DRAIN) && (occ == OCC_ONE);
    end
  end

endmodule

[hw/rtl/replacement_selection_run_generator.sv]
// Channel   Dir  Payload                                            Handshake
// in_ch     in   cmd, record_value                                  valid/ready
// out_ch    out  out_value, run_index, first_of_run, final_record   valid/ready
// cfg       in   cfg_wdata (work_size)                              cfg_we, no wait
//
// Steps: a record while the work area fills is accepted, then appended. Once
// full, a record goes through accept, decide, occ slot reads, last compare,
// emit and write-back; the single read port of the work RAM sets the scan
// pace, one slot per cycle. A drain loops decide to write-back per result.
// Reset (rst, sync): area empty, run 0, work_size 64; RAM is not cleared.
// Stalls: one result is held in the output register; the next emit waits
// for it to be taken. New requests are taken only between items.
module replacement_selection_run_generator import rsrg_pkg::*; #(
  parameter int WORK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  rsrg_in_if.sink          in_ch,
  rsrg_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  rsrg_cmd_t cmd;
  rsrg_sts_t sts;

  // sequencer: fill, scan, emit, write-back, drain loop
  rsrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // work RAM, occupancy, run state, min search and output register
  rsrg_dp #(
    .WORK_DEPTH (WORK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (in_ch.cmd),
    .in_value  (in_ch.record_value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.out_value),
    .out_run   (out_ch.run_index),
    .out_first (out_ch.first_of_run),
    .out_final (out_ch.final_record),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef ASSERT_OFF
  // the output register is only loaded when its last result has gone
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register still full");

  // a new result appears only after an emit command
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.emit))
    else $error("output valid without emit");

  // appends only while the area still has room
  a_fill_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_wr |-> !sts.area_full)
    else $error("fill write into a full area");

  // drain leaves the area empty
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_end |=> sts.occ_zero)
    else $error("area not empty after drain");
`endif

endmodule
